// File: rtl/base64_byte_encoder_assert.svh
// Assertion macros shared by the encoder modules.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef BASE64_BYTE_ENCODER_ASSERT_SVH
`define BASE64_BYTE_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64E_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B64E_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/b64e_pkg.sv
package b64e_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_t;

	typedef struct packed {
		logic [6:0] text_char;
		logic       end_of_text;
	} out_t;

	// One group of three bytes as it travels from the front to the back.
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  pad_count;
		logic        last;
	} grp_t;

	localparam logic [6:0] PAD_CHAR = 7'd61;

	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;

	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] c;
		if (v < 6'd26) begin
			c = 7'(v) + 7'd65;
		end else if (v < 6'd52) begin
			c = 7'(v) + 7'd71;
		end else if (v < 6'd62) begin
			c = 7'(v) - 7'd4;
		end else if (v == 6'd62) begin
			c = 7'd43;
		end else begin
			c = 7'd47;
		end
		return c;
	endfunction

endpackage

// File: rtl/base64_byte_encoder.sv
// Base64 encoder (standard alphabet, '=' padding): one raw byte in per transfer, one
// ASCII character out per transfer. A front stage gathers bytes into groups of three
// and hands each complete or final group to a two-entry queue; a back stage turns each
// group into four characters, one per cycle while the output is drained, into a
// registered output. Bytes are taken one per cycle while the queue has room, and
// characters leave at one per cycle while out_ready is held, so the back stage's
// single character lane sets the pace of a long message. Once its completing byte
// is taken, a group passes through the queue and the group register before its first
// character is registered. The last character of each message carries end_of_text.
module base64_byte_encoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  b64e_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output b64e_pkg::out_t  out_data
);

	logic           grp_push;
	logic           grp_full;
	logic           grp_pop;
	logic           grp_valid;
	b64e_pkg::grp_t grp_in;
	b64e_pkg::grp_t grp_out;

	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.grp_full (grp_full),
		.grp_push (grp_push),
		.grp_data (grp_in)
	);

	b64e_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (grp_push),
		.push_data (grp_in),
		.full      (grp_full),
		.pop       (grp_pop),
		.not_empty (grp_valid),
		.pop_data  (grp_out)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (grp_valid),
		.grp_data  (grp_out),
		.grp_pop   (grp_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: rtl/b64e_front.sv
`include "base64_byte_encoder_assert.svh"

module b64e_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  b64e_pkg::in_t   in_data,
	input  logic            grp_full,
	output logic            grp_push,
	output b64e_pkg::grp_t  grp_data
);

	logic [7:0] pend0_q;
	logic [7:0] pend1_q;
	logic [1:0] cnt_q;
	logic       accept;

	assign in_ready = !grp_full;
	assign accept   = in_valid && in_ready;
	assign grp_push = accept && (cnt_q == b64e_pkg::CNT_TWO || in_data.final_byte);

	always_comb begin
		grp_data.last = in_data.final_byte;
		case (cnt_q)
			b64e_pkg::CNT_NONE: begin
				grp_data.bits      = {in_data.data_byte, 16'h0000};
				grp_data.pad_count = 2'd2;
			end
			b64e_pkg::CNT_ONE: begin
				grp_data.bits      = {pend0_q, in_data.data_byte, 8'h00};
				grp_data.pad_count = 2'd1;
			end
			default: begin
				grp_data.bits      = {pend0_q, pend1_q, in_data.data_byte};
				grp_data.pad_count = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= b64e_pkg::CNT_NONE;
		end else if (accept) begin
			if (grp_push) begin
				cnt_q <= b64e_pkg::CNT_NONE;
			end else begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !grp_push) begin
			if (cnt_q == b64e_pkg::CNT_NONE) begin
				pend0_q <= in_data.data_byte;
			end else begin
				pend1_q <= in_data.data_byte;
			end
		end
	end

	`B64E_ASSERT_SAME(a_cnt_range, 1'b1, cnt_q != 2'd3, "pending count out of range")

endmodule

// File: rtl/b64e_fifo.sv
`include "base64_byte_encoder_assert.svh"

module b64e_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b64e_pkg::grp_t  push_data,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output b64e_pkg::grp_t  pop_data
);

	b64e_pkg::grp_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`B64E_ASSERT_SAME(a_no_overflow, push, !full, "group queue written while full")
	`B64E_ASSERT_SAME(a_no_underflow, pop, not_empty, "group queue read while empty")

endmodule

// File: rtl/b64e_back.sv
`include "base64_byte_encoder_assert.svh"

module b64e_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            grp_valid,
	input  b64e_pkg::grp_t  grp_data,
	output logic            grp_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output b64e_pkg::out_t  out_data
);

	b64e_pkg::grp_t grp_q;
	logic           busy_q;
	logic [1:0]     idx_q;
	logic           ovalid_q;
	b64e_pkg::out_t out_q;
	logic           adv;
	logic [5:0]     slice;
	logic           is_pad;

	// When busy, a character enters the output register if it is empty or being drained.
	assign adv     = busy_q && (!ovalid_q || out_ready);
	assign grp_pop = grp_valid && (!busy_q || (adv && idx_q == 2'd3));

	always_comb begin
		case (idx_q)
			2'd0:    slice = grp_q.bits[23:18];
			2'd1:    slice = grp_q.bits[17:12];
			2'd2:    slice = grp_q.bits[11:6];
			default: slice = grp_q.bits[5:0];
		endcase
	end

	assign is_pad = ({1'b0, idx_q} + {1'b0, grp_q.pad_count}) >= 3'd4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			idx_q    <= 2'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (grp_pop) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (adv) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grp_pop) begin
			grp_q <= grp_data;
		end
		if (adv) begin
			out_q.text_char   <= is_pad ? b64e_pkg::PAD_CHAR : b64e_pkg::b64_char(slice);
			out_q.end_of_text <= grp_q.last && (idx_q == 2'd3);
		end
	end

	assign out_valid = ovalid_q;
	assign out_data  = out_q;

	`B64E_ASSERT_SAME(a_reload_at_end, grp_pop && busy_q, adv && idx_q == 2'd3,
		"new group loaded before the current one finished")

endmodule
